@@ rtl/core/min_tracking_stack_top_macros.svh @@
// Assertion macros used by the min tracking stack checker.
`ifndef MIN_TRACKING_STACK_TOP_MACROS_SVH
`define MIN_TRACKING_STACK_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/mts_pkg.sv @@
// Types and constants of the min tracking stack.
package mts_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int DATA_W    = 32;
  localparam int DEPTH_W   = 6;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef logic signed [DATA_W-1:0] data_t;

  // Shift command broadcast along a chain of cells.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

@@ rtl/core/mts_cell.sv @@
// One stack cell: holds a value, takes it from the neighbor above or below.
module mts_cell (
  input  logic               clk,
  input  mts_pkg::shift_ctl_t ctl,
  input  mts_pkg::data_t      up_data,
  input  mts_pkg::data_t      down_data,
  output mts_pkg::data_t      data
);
  import mts_pkg::*;

  data_t data_r;
  data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.push) begin
      data_nxt = up_data;
    end else if (ctl.pop) begin
      data_nxt = down_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

@@ rtl/core/mts_chain.sv @@
// Row of stack cells; cell 0 is the top of stack.
module mts_chain #(
  parameter int DEPTH = mts_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  mts_pkg::shift_ctl_t ctl,
  input  mts_pkg::data_t      push_data,
  output mts_pkg::data_t      top_data
);
  import mts_pkg::*;

  data_t cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t up_d;
    data_t down_d;
    if (i == 0) begin : g_first
      assign up_d = push_data;
    end else begin : g_mid
      assign up_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign down_d = '0;
    end else begin : g_inner
      assign down_d = cell_q[i+1];
    end
    mts_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .up_data   (up_d),
      .down_data (down_d),
      .data      (cell_q[i])
    );
  end

  assign top_data = cell_q[0];

endmodule

@@ rtl/core/min_tracking_stack_top.sv @@
// Result registered after each input transfer; one item per cycle unless the output stalls.
// Each push that finds room, or pop that finds data, shifts the data chain and, when
// needed, the minimum chain by one cell; the result register frees as it is taken.
// Reset (rst_n low, synchronous) empties both stacks and drops any pending
// result; cell contents are not cleared.
module min_tracking_stack_top #(
  parameter int DEPTH = mts_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [0:0]  in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [5:0] depth, [37:6] popped_value, [69:38] min_value
  output logic [2:0]  out_tuser   // [1:0] status, [2] min_valid
);
  import mts_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] min_cnt_r, min_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  data_t            popped_r, popped_nxt;

  logic       accept;
  logic       is_pop;
  logic       full;
  logic       empty;
  data_t      in_value;
  data_t      data_top;
  data_t      min_top;
  shift_ctl_t data_ctl;
  shift_ctl_t min_ctl;
  data_t      min_out;
  logic       min_valid;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_pop    = (cmd_t'(in_tuser[0]) == CMD_POP);
  assign in_value  = in_tdata;
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign empty     = (cnt_r == '0);

  always_comb begin
    data_ctl.push = accept && !is_pop && !full;
    data_ctl.pop  = accept && is_pop && !empty;
    // a new minimum, or a tie with it, enters the minimum stack
    min_ctl.push  = data_ctl.push && ((min_cnt_r == '0) || (in_value <= min_top));
    min_ctl.pop   = data_ctl.pop && (min_cnt_r != '0) && (data_top == min_top);
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    min_cnt_nxt   = min_cnt_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    popped_nxt    = popped_r;
    if (data_ctl.push) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (data_ctl.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    if (min_ctl.push) begin
      min_cnt_nxt = min_cnt_r + 1'b1;
    end else if (min_ctl.pop) begin
      min_cnt_nxt = min_cnt_r - 1'b1;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      popped_nxt    = data_ctl.pop ? data_top : '0;
      if (!is_pop) begin
        status_nxt = full ? STAT_FULL : STAT_DONE;
      end else begin
        status_nxt = empty ? STAT_EMPTY : STAT_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      min_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      min_cnt_r   <= min_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    popped_r <= popped_nxt;
  end

  mts_chain #(.DEPTH(DEPTH)) u_data_chain (
    .clk       (clk),
    .ctl       (data_ctl),
    .push_data (in_value),
    .top_data  (data_top)
  );

  mts_chain #(.DEPTH(DEPTH)) u_min_chain (
    .clk       (clk),
    .ctl       (min_ctl),
    .push_data (in_value),
    .top_data  (min_top)
  );

  // State holds while a result waits, so it reads straight from the counters.
  assign min_valid = (min_cnt_r != '0);
  assign min_out   = min_valid ? min_top : '0;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, min_out, popped_r, DEPTH_W'(cnt_r)};
  assign out_tuser  = {min_valid, status_r};

endmodule

@@ rtl/core/mts_checker.sv @@
// Port-level checker for the min tracking stack, bound to the top level.
`include "min_tracking_stack_top_macros.svh"

module mts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import mts_pkg::*;

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // a stalled result holds
  `MTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // no minimum means an empty stack and a zero minimum field
  `MTS_ASSERT_NOW(a_min_empty, clk, rst_n, out_tvalid && !out_tuser[2], out_tdata[5:0] == 6'd0 && out_tdata[69:38] == 32'd0)
  // a refused push leaves a full, non-empty stack and pops nothing
  `MTS_ASSERT_NOW(a_full_refuse, clk, rst_n, out_tvalid && out_tuser[1:0] == STAT_FULL, out_tuser[2] && out_tdata[37:6] == 32'd0)
  // a refused pop sees an empty stack
  `MTS_ASSERT_NOW(a_empty_refuse, clk, rst_n, out_tvalid && out_tuser[1:0] == STAT_EMPTY, !out_tuser[2] && out_tdata[37:6] == 32'd0)
  // every input transfer yields a result in the next cycle
  `MTS_ASSERT_NEXT(a_result_follows, clk, rst_n, in_xfer, out_tvalid)

endmodule

bind min_tracking_stack_top mts_checker u_mts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ test/tb_top.sv @@
// Testbench for min_tracking_stack_top: push/pop traffic against a running-minimum predictor.
`timescale 1ns / 100ps

module tb_top;
  import mts_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    cmd_t  cmd;
    data_t value;
  } stack_op_t;

  typedef struct packed {
    status_t           status;
    logic [DEPTH_W-1:0] depth;
    data_t             popped;
    data_t             min_val;
    logic              min_valid;
  } stack_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;

  min_tracking_stack_top #(.DEPTH(STACK_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  stack_op_t     pending_ops[$];
  stack_result_t results_due[$];

  // Predictor state: data stack and running-minimum stack
  data_t stack_vals[STACK_DEPTH];
  data_t min_vals[STACK_DEPTH];
  int    stack_cnt;
  int    min_cnt;

  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_off;
  logic in_taken;
  int   mismatch_cnt;
  int   cycle_cnt;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic apply_stack_op(input cmd_t cmd, input data_t val);
    stack_result_t res;
    res = '0;
    res.status = STAT_DONE;
    if (cmd == CMD_PUSH) begin
      if (stack_cnt >= STACK_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        stack_vals[stack_cnt] = val;
        stack_cnt++;
        if (min_cnt == 0 || val <= min_vals[min_cnt-1]) begin
          min_vals[min_cnt] = val;
          min_cnt++;
        end
      end
    end else begin
      if (stack_cnt == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.popped = stack_vals[stack_cnt-1];
        stack_cnt--;
        // drop the minimum only when the popped copy is the recorded one
        if (min_cnt > 0 && res.popped == min_vals[min_cnt-1])
          min_cnt--;
      end
    end
    res.depth = stack_cnt[DEPTH_W-1:0];
    if (min_cnt > 0) begin
      res.min_val   = min_vals[min_cnt-1];
      res.min_valid = 1'b1;
    end
    results_due.push_back(res);
  endtask

  function automatic data_t pick_value();
    data_t v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = int'($urandom_range(8)) - 4;
      7:          v = 32'sh8000_0000;
      8:          v = 32'sh7fff_ffff;
      default:    v = int'($urandom_range(200)) - 100;
    endcase
    return v;
  endfunction

  task automatic add_op(input cmd_t cmd, input data_t val);
    stack_op_t op;
    op.cmd   = cmd;
    op.value = val;
    pending_ops.push_back(op);
  endtask

  task automatic add_run(input int len, input int push_pct);
    for (int i = 0; i < len; i++)
      add_op(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP, pick_value());
  endtask

  // Segments of push-heavy, balanced and pop-heavy traffic walk the depth
  // between empty and full.
  task automatic add_random(input int count);
    int left;
    int len;
    int bias;
    left = count;
    while (left > 0) begin
      case ($urandom_range(2))
        0:       bias = 90;
        1:       bias = 50;
        default: bias = 12;
      endcase
      len = $urandom_range(20, 60);
      if (len > left) len = left;
      add_run(len, bias);
      left -= len;
    end
  endtask

  task automatic drain_phase();
    while (pending_ops.size() != 0 || in_tvalid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Driver: present the next pending item once the current one is taken
  always @(negedge clk) begin
    stack_op_t op;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        op = pending_ops.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= op.value;
        in_tuser  <= op.cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off)
      out_tready <= 1'b0;
    else
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Predict on every input transfer
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      apply_stack_op(cmd_t'(in_tuser[0]), data_t'(in_tdata));
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    stack_result_t got;
    stack_result_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      got.status    = status_t'(out_tuser[1:0]);
      got.min_valid = out_tuser[2];
      got.depth     = out_tdata[5:0];
      got.popped    = out_tdata[37:6];
      got.min_val   = out_tdata[69:38];
      if (results_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected: status=%0d depth=%0d popped=%0d min=%0d min_valid=%0b",
                   got.status, got.depth, got.popped, got.min_val, got.min_valid);
      end else begin
        exp = results_due.pop_front();
        if (got.status !== exp.status || got.depth !== exp.depth ||
            got.popped !== exp.popped || got.min_val !== exp.min_val ||
            got.min_valid !== exp.min_valid) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch exp: status=%0d depth=%0d popped=%0d min=%0d min_valid=%0b",
                     exp.status, exp.depth, exp.popped, exp.min_val, exp.min_valid);
            $display("         got: status=%0d depth=%0d popped=%0d min=%0d min_valid=%0b",
                     got.status, got.depth, got.popped, got.min_val, got.min_valid);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    hold_off       = 1'b0;
    in_taken       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_cnt   = 0;
    cycle_cnt      = 0;
    stack_cnt      = 0;
    min_cnt        = 0;

    // Directed: pop on empty, extremes, duplicate minima, alternating bits
    add_op(CMD_POP,  32'sh0000_1234);
    add_op(CMD_PUSH, 32'sh0000_0000);
    add_op(CMD_PUSH, 32'shffff_ffff);
    add_op(CMD_PUSH, 32'sh7fff_ffff);
    add_op(CMD_PUSH, 32'sh8000_0000);
    add_op(CMD_PUSH, 32'sh8000_0000);
    add_op(CMD_PUSH, 32'sh0000_0005);
    repeat (6) add_op(CMD_POP, 32'shffff_ffff);
    add_op(CMD_POP,  32'sh0000_0000);
    add_op(CMD_PUSH, 32'sh5555_5555);
    add_op(CMD_PUSH, 32'shaaaa_aaaa);
    add_op(CMD_POP,  32'sh0000_0000);
    add_op(CMD_POP,  32'sh0000_0000);
    add_op(CMD_PUSH, 32'sh0000_0003);
    add_op(CMD_PUSH, 32'sh0000_0003);
    add_op(CMD_PUSH, 32'sh0000_0004);
    repeat (3) add_op(CMD_POP, 32'sh0000_0000);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase: no idling; fill past full, drain past empty, long output stall
    add_run(STACK_DEPTH + 2, 100);
    add_run(STACK_DEPTH + 3, 0);
    add_random(90);
    repeat (12) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
    drain_phase();

    send_idle_pct = 83;
    add_random(90);
    drain_phase();

    send_idle_pct  = 0;
    recv_stall_pct = 83;
    add_random(90);
    drain_phase();

    send_idle_pct  = 10;
    recv_stall_pct = 10;
    add_random(90);
    drain_phase();

    repeat (5) @(posedge clk);
    if (mismatch_cnt == 0 && results_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
